### hw/rtl/mmpid_pkg.sv
package mmpid_pkg;

    localparam int CHANNELS = 4;
    localparam int CH_W     = 2;

    // Product and quotient widths of the PID terms.
    localparam int PROD_W    = 49;
    localparam int DIV_MAG_W = 52;
    localparam int DIV_STEPS = 4;
    localparam int DIV_CYC   = DIV_MAG_W / DIV_STEPS;
    localparam int QUOT_W    = 50;
    localparam int PID_W     = 52;

    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_POS      = 2'd1;
    localparam logic [1:0] MODE_SPEED    = 2'd2;
    localparam logic [1:0] MODE_POS_SPD  = 2'd3;

    localparam logic [1:0] CODE_IDLE     = 2'd0;
    localparam logic [1:0] CODE_REVERSE  = 2'd1;
    localparam logic [1:0] CODE_FORWARD  = 2'd2;
    localparam logic [1:0] CODE_BRAKE    = 2'd3;

    localparam logic [1:0] REG_MAX_DRIVE   = 2'd0;
    localparam logic [1:0] REG_INT_LIMIT   = 2'd1;
    localparam logic [1:0] REG_GOAL_WINDOW = 2'd2;
    localparam logic [1:0] REG_SPEED_SCALE = 2'd3;

    localparam logic [11:0] MAX_DRIVE_RST   = 12'd2600;
    localparam logic [15:0] INT_LIMIT_RST   = 16'd5500;
    localparam logic [9:0]  GOAL_WINDOW_RST = 10'd10;
    localparam logic [7:0]  SPEED_SCALE_RST = 8'd25;
    localparam logic signed [15:0] DIVISOR_RST = 16'sd100;

    typedef struct packed {
        logic signed [31:0] last_position;
        logic signed [31:0] last_error;
        logic signed [16:0] error_sum;
        logic signed [15:0] p_divisor;
        logic signed [15:0] i_divisor;
        logic signed [15:0] d_divisor;
        logic [11:0]        held_level;
        logic [1:0]         held_code;
    } t_chan_state;

    localparam t_chan_state STATE_RST = '{
        last_position: 32'sd0,
        last_error:    32'sd0,
        error_sum:     17'sd0,
        p_divisor:     DIVISOR_RST,
        i_divisor:     DIVISOR_RST,
        d_divisor:     DIVISOR_RST,
        held_level:    12'd0,
        held_code:     CODE_IDLE
    };

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        logic signed [31:0] res;
        if (v > 43'sh0_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -43'sh0_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/mmpid_state_mem.sv
module mmpid_state_mem
    import mmpid_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [CH_W-1:0]   i_rd_addr,
    output t_chan_state       o_rd_data,
    input  logic              i_wr_en,
    input  logic [CH_W-1:0]   i_wr_addr,
    input  t_chan_state       i_wr_data
);

    t_chan_state           r_mem [CHANNELS];
    logic [CHANNELS-1:0]   r_vld;
    t_chan_state           r_rd_data;

    // An entry that was never written reads as its reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_vld[i_rd_addr] ? r_mem[i_rd_addr] : STATE_RST;
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/mmpid_div.sv
module mmpid_div
    import mmpid_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [PROD_W-1:0] i_dividend,
    input  logic signed [15:0]       i_divisor,
    output logic                     o_done,
    output logic signed [QUOT_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(DIV_CYC + 1);

    logic [DIV_MAG_W-1:0] r_n;
    logic [17:0]          r_rem;
    logic [16:0]          r_d;
    logic                 r_neg;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_MAG_W-1:0] n_n;
    logic [17:0]          n_rem;
    logic [PROD_W-1:0]    a_mag;
    logic [16:0]          d_mag;

    always_comb begin
        a_mag = i_dividend[PROD_W-1] ? PROD_W'(-i_dividend) : PROD_W'(i_dividend);
        d_mag = i_divisor[15] ? 17'(-{i_divisor[15], i_divisor})
                              : 17'({i_divisor[15], i_divisor});
    end

    // Restoring division, several quotient bits per cycle.
    always_comb begin
        n_n   = r_n;
        n_rem = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            n_rem = {n_rem[16:0], n_n[DIV_MAG_W-1]};
            n_n   = {n_n[DIV_MAG_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_d}) begin
                n_rem  = n_rem - {1'b0, r_d};
                n_n[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_n   <= n_n;
                r_rem <= n_rem;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_start) begin
                r_n   <= DIV_MAG_W'(a_mag);
                r_rem <= '0;
                r_d   <= d_mag;
                r_neg <= i_dividend[PROD_W-1] ^ i_divisor[15];
                r_cnt <= CNT_W'(DIV_CYC);
                r_busy <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? QUOT_W'(-r_n[QUOT_W-1:0]) : QUOT_W'(r_n[QUOT_W-1:0]);

endmodule

### hw/rtl/multi_mode_motor_pid.sv
// Per-channel PID motor regulator with a clamped integral.
// Input channel: i_valid / o_ready carry one control tick per item: channel,
// mode, measured and goal position, goal speed and the six gain fields.
// Output channel: o_valid / i_ready carry one result per tick: the channel,
// the PWM level, the drive code and the active flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (max drive, integral limit, goal window, speed scale) in the same cycle.
// Items are processed one at a time. Per-channel state sits in a small
// memory that is read when the item is accepted and written back at its end.
// A regulating tick runs through the load, goal check, error, sum and product
// steps, then three truncating divisions on one shared divider that retires
// four quotient bits a cycle, one division per term, then a finish step and
// an output step that registers the result. An off tick or one that reaches
// its goal goes from the goal check straight to the output step.
// o_ready rises again once the result has moved into the output register,
// so a stalled receiver holds back at most one further item.
// Reset restores the register defaults, marks all channel state as reset
// (divisors 100, everything else zero) and empties the output register.
module multi_mode_motor_pid
    import mmpid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_channel,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_position,
    input  logic signed [31:0] i_goal_position,
    input  logic signed [31:0] i_goal_speed,
    input  logic signed [15:0] i_kp_num,
    input  logic signed [15:0] i_kp_den,
    input  logic signed [15:0] i_ki_num,
    input  logic signed [15:0] i_ki_den,
    input  logic signed [15:0] i_kd_num,
    input  logic signed [15:0] i_kd_den,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_out_channel,
    output logic [11:0]        o_drive_level,
    output logic [1:0]         o_drive_code,
    output logic               o_active,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_GOAL, S_ERR, S_SUM, S_MUL, S_DIV, S_FIN, S_OUT
    } t_state;

    t_state r_state;

    logic [11:0] r_max_drive;
    logic [15:0] r_int_limit;
    logic [9:0]  r_goal_window;
    logic [7:0]  r_speed_scale;

    // Latched item.
    logic [1:0]         r_ch;
    logic [1:0]         r_mode;
    logic signed [31:0] r_pos;
    logic signed [31:0] r_gpos;
    logic signed [31:0] r_gspd;
    logic signed [15:0] r_kpn, r_kpd, r_kin, r_kid, r_kdn, r_kdd;

    t_chan_state        r_st;
    logic signed [32:0] r_pos_err;
    logic signed [32:0] r_diff;
    logic signed [41:0] r_speed;
    logic signed [31:0] r_err;
    logic signed [16:0] r_sum;
    logic signed [32:0] r_derr;
    logic signed [PROD_W-1:0] r_prod_p, r_prod_i, r_prod_d;
    logic signed [PID_W-1:0]  r_pid;
    logic [1:0]         r_term;
    logic               r_div_go;

    logic               r_wr_en;
    t_chan_state        r_wr_data;

    logic               r_res_active;
    logic [11:0]        r_res_level;
    logic [1:0]         r_res_code;

    logic               r_o_valid;
    logic [1:0]         r_o_channel;
    logic [11:0]        r_o_level;
    logic [1:0]         r_o_code;
    logic               r_o_active;

    t_chan_state        mem_rd;
    logic               in_acc;
    logic               div_done;
    logic signed [QUOT_W-1:0] div_quot;
    logic signed [PROD_W-1:0] div_a;
    logic signed [15:0]       div_d;

    logic [32:0]        abs_err;
    logic               at_goal;
    logic signed [42:0] spd_error;
    logic signed [33:0] sum_raw;
    logic signed [33:0] lim;
    logic signed [16:0] sum_clamped;
    logic signed [PID_W-1:0] pid_mag;
    logic [11:0]        level;
    logic [1:0]         fin_code;
    t_chan_state        ld_st;
    t_chan_state        brake_st;
    t_chan_state        fin_st;

    assign in_acc  = i_valid && o_ready;
    assign o_ready = (r_state == S_IDLE);

    mmpid_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (i_channel),
        .o_rd_data (mem_rd),
        .i_wr_en   (r_wr_en),
        .i_wr_addr (r_ch),
        .i_wr_data (r_wr_data)
    );

    always_comb begin
        case (r_term)
            2'd0: begin
                div_a = r_prod_p;
                div_d = r_st.p_divisor;
            end
            2'd1: begin
                div_a = r_prod_i;
                div_d = r_st.i_divisor;
            end
            default: begin
                div_a = r_prod_d;
                div_d = r_st.d_divisor;
            end
        endcase
    end

    mmpid_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (div_a),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        abs_err = r_pos_err[32] ? 33'(-r_pos_err) : 33'(r_pos_err);
        at_goal = (r_pos_err == 33'sd0) || (abs_err < {23'd0, r_goal_window});
        if (r_mode == MODE_POS_SPD) begin
            if ((r_pos_err[32] && !r_gspd[31] && r_gspd != 32'sd0)
                || (!r_pos_err[32] && r_pos_err != 33'sd0 && r_gspd[31])) begin
                at_goal = 1'b1;
            end
        end
        spd_error = 43'(r_gspd) - 43'(r_speed);
        sum_raw   = 34'(r_st.error_sum) + 34'(r_err);
        lim       = $signed({18'd0, r_int_limit});
        if (sum_raw > lim) begin
            sum_clamped = 17'(lim);
        end else if (sum_raw < -lim) begin
            sum_clamped = 17'(-lim);
        end else begin
            sum_clamped = 17'(sum_raw);
        end
        pid_mag = (r_pid > 0) ? r_pid : PID_W'(-r_pid);
        level   = (pid_mag > $signed({40'd0, r_max_drive})) ? r_max_drive
                                                            : pid_mag[11:0];
        fin_code = (r_pid > 0) ? CODE_FORWARD : CODE_REVERSE;

        // A zero denominator keeps the stored divisor.
        ld_st = mem_rd;
        if (r_kpd != 16'sd0) ld_st.p_divisor = r_kpd;
        if (r_kid != 16'sd0) ld_st.i_divisor = r_kid;
        if (r_kdd != 16'sd0) ld_st.d_divisor = r_kdd;

        brake_st            = r_st;
        brake_st.last_error = 32'sd0;
        brake_st.error_sum  = 17'sd0;
        brake_st.held_level = 12'd0;
        brake_st.held_code  = CODE_BRAKE;

        fin_st               = r_st;
        fin_st.error_sum     = r_sum;
        fin_st.last_position = r_pos;
        fin_st.last_error    = r_err;
        fin_st.held_level    = level;
        fin_st.held_code     = fin_code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_drive   <= MAX_DRIVE_RST;
            r_int_limit   <= INT_LIMIT_RST;
            r_goal_window <= GOAL_WINDOW_RST;
            r_speed_scale <= SPEED_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MAX_DRIVE:   r_max_drive   <= i_cfg_data[11:0];
                REG_INT_LIMIT:   r_int_limit   <= i_cfg_data;
                REG_GOAL_WINDOW: r_goal_window <= i_cfg_data[9:0];
                REG_SPEED_SCALE: r_speed_scale <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wr_en   <= 1'b0;
            r_div_go  <= 1'b0;
            r_o_valid <= 1'b0;
            r_term    <= '0;
        end else begin
            r_wr_en  <= 1'b0;
            r_div_go <= 1'b0;
            // In S_OUT the output register is reloaded below instead.
            if (o_valid && i_ready && r_state != S_OUT) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_ch   <= i_channel;
                        r_mode <= i_mode;
                        r_pos  <= i_position;
                        r_gpos <= i_goal_position;
                        r_gspd <= i_goal_speed;
                        r_kpn  <= i_kp_num;
                        r_kpd  <= i_kp_den;
                        r_kin  <= i_ki_num;
                        r_kid  <= i_ki_den;
                        r_kdn  <= i_kd_num;
                        r_kdd  <= i_kd_den;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_st      <= ld_st;
                    r_pos_err <= 33'(r_gpos) - 33'(r_pos);
                    r_diff    <= 33'(r_pos) - 33'(mem_rd.last_position);
                    r_state   <= S_GOAL;
                end
                S_GOAL: begin
                    r_speed <= $signed({1'b0, r_speed_scale}) * r_diff;
                    if (r_mode == MODE_OFF) begin
                        r_wr_en      <= 1'b1;
                        r_wr_data    <= r_st;
                        r_res_level  <= r_st.held_level;
                        r_res_code   <= r_st.held_code;
                        r_res_active <= 1'b0;
                        r_state      <= S_OUT;
                    end else if (r_mode != MODE_SPEED && at_goal) begin
                        r_wr_en      <= 1'b1;
                        r_wr_data    <= brake_st;
                        r_res_level  <= 12'd0;
                        r_res_code   <= CODE_BRAKE;
                        r_res_active <= 1'b0;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR: begin
                    r_err   <= (r_mode == MODE_POS) ? sat32(43'(r_pos_err))
                                                    : sat32(spd_error);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= sum_clamped;
                    r_derr  <= 33'(r_err) - 33'(r_st.last_error);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod_p <= PROD_W'(r_kpn * r_err);
                    r_prod_i <= PROD_W'(r_kin * r_sum);
                    r_prod_d <= PROD_W'(r_kdn * r_derr);
                    r_pid    <= '0;
                    r_term   <= 2'd0;
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_pid <= r_pid + PID_W'(div_quot);
                        if (r_term == 2'd2) begin
                            r_state <= S_FIN;
                        end else begin
                            r_term   <= r_term + 2'd1;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    r_wr_en      <= 1'b1;
                    r_wr_data    <= fin_st;
                    r_res_level  <= level;
                    r_res_code   <= fin_code;
                    r_res_active <= 1'b1;
                    r_state      <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || i_ready) begin
                        r_o_valid   <= 1'b1;
                        r_o_channel <= r_ch;
                        r_o_level   <= r_res_level;
                        r_o_code    <= r_res_code;
                        r_o_active  <= r_res_active;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_channel = r_o_channel;
    assign o_drive_level = r_o_level;
    assign o_drive_code  = r_o_code;
    assign o_active      = r_o_active;

endmodule

### hw/rtl/mmpid_checker.sv
module mmpid_assert
    import mmpid_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [1:0]  o_out_channel,
    input logic [11:0] o_drive_level,
    input logic [1:0]  o_drive_code,
    input logic        o_active
);

    // A result waiting on a stalled receiver keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_drive_level)
            && $stable(o_drive_code) && $stable(o_out_channel))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // Only one item is in flight: an accept closes the input side.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after accept");

    a_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_drive_code == CODE_BRAKE |-> o_drive_level == 12'd0 && !o_active)
        else $error("brake with level or active");

    a_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_active |-> o_drive_code == CODE_FORWARD
            || o_drive_code == CODE_REVERSE)
        else $error("active without forward or reverse");

endmodule

bind multi_mode_motor_pid mmpid_assert u_mmpid_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_out_channel (o_out_channel),
    .o_drive_level (o_drive_level),
    .o_drive_code  (o_drive_code),
    .o_active      (o_active)
);

### tb/sv/mmpid_checker.sv
`timescale 1ns / 1ps

module mmpid_checker
    import mmpid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_channel,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_position,
    input  logic signed [31:0] i_goal_position,
    input  logic signed [31:0] i_goal_speed,
    input  logic signed [15:0] i_kp_num,
    input  logic signed [15:0] i_kp_den,
    input  logic signed [15:0] i_ki_num,
    input  logic signed [15:0] i_ki_den,
    input  logic signed [15:0] i_kd_num,
    input  logic signed [15:0] i_kd_den,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [1:0]         i_out_channel,
    input  logic [11:0]        i_drive_level,
    input  logic [1:0]         i_drive_code,
    input  logic               i_active,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_brakes,
    output int                 o_regulating
);

    typedef struct packed {
        logic [1:0]  chan;
        logic [11:0] level;
        logic [1:0]  code;
        logic        active;
    } drive_t;

    drive_t drive_q[$];

    logic [11:0] max_drive;
    logic [15:0] int_limit;
    logic [9:0]  goal_window;
    logic [7:0]  speed_scale;

    longint last_pos[CHANNELS];
    longint last_err[CHANNELS];
    longint err_sum[CHANNELS];
    longint p_div[CHANNELS];
    longint i_div[CHANNELS];
    longint d_div[CHANNELS];
    logic [11:0] held_level[CHANNELS];
    logic [1:0]  held_code[CHANNELS];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Advances one channel's regulator state and returns the drive it commands.
    function automatic drive_t regulate_tick();
        drive_t r;
        int     ch;
        longint pos, gpos, gspd, pos_err, spd_err, err, sum, lim, pid, mag, abs_err;
        logic   at_goal;
        ch   = i_channel;
        pos  = i_position;
        gpos = i_goal_position;
        gspd = i_goal_speed;
        r.chan = i_channel;
        if (i_kp_den != 0) p_div[ch] = i_kp_den;
        if (i_ki_den != 0) i_div[ch] = i_ki_den;
        if (i_kd_den != 0) d_div[ch] = i_kd_den;
        if (i_mode == MODE_OFF) begin
            r.level  = held_level[ch];
            r.code   = held_code[ch];
            r.active = 1'b0;
            return r;
        end
        pos_err = gpos - pos;
        spd_err = gspd - longint'(speed_scale) * (pos - last_pos[ch]);
        at_goal = 1'b0;
        if (i_mode == MODE_POS || i_mode == MODE_POS_SPD) begin
            abs_err = (pos_err < 0) ? -pos_err : pos_err;
            at_goal = (pos_err == 0) || (abs_err < longint'(goal_window));
            // Overshoot: the error points against the commanded direction.
            if (i_mode == MODE_POS_SPD && ((pos_err < 0 && gspd > 0) || (pos_err > 0 && gspd < 0)))
                at_goal = 1'b1;
        end
        if (at_goal) begin
            last_err[ch]   = 0;
            err_sum[ch]    = 0;
            held_level[ch] = '0;
            held_code[ch]  = CODE_BRAKE;
            r.level  = '0;
            r.code   = CODE_BRAKE;
            r.active = 1'b0;
            return r;
        end
        err = clamp32((i_mode == MODE_POS) ? pos_err : spd_err);
        lim = longint'(int_limit);
        sum = err_sum[ch] + err;
        if (sum > lim) sum = lim;
        else if (sum < -lim) sum = -lim;
        err_sum[ch] = sum;
        pid = (longint'(i_kp_num) * err) / p_div[ch]
            + (longint'(i_ki_num) * sum) / i_div[ch]
            + (longint'(i_kd_num) * (err - last_err[ch])) / d_div[ch];
        last_pos[ch] = pos;
        last_err[ch] = err;
        if (pid > 0) begin
            mag = pid;
            held_code[ch] = CODE_FORWARD;
        end else begin
            mag = -pid;
            held_code[ch] = CODE_REVERSE;
        end
        if (mag > longint'(max_drive)) mag = longint'(max_drive);
        held_level[ch] = mag[11:0];
        r.level  = held_level[ch];
        r.code   = held_code[ch];
        r.active = 1'b1;
        return r;
    endfunction

    assign o_pending = drive_q.size();

    always @(posedge i_clk) begin
        drive_t exp_d;
        if (!i_rst_n) begin
            max_drive   <= MAX_DRIVE_RST;
            int_limit   <= INT_LIMIT_RST;
            goal_window <= GOAL_WINDOW_RST;
            speed_scale <= SPEED_SCALE_RST;
            for (int c = 0; c < CHANNELS; c++) begin
                last_pos[c] = 0;
                last_err[c] = 0;
                err_sum[c] = 0;
                p_div[c] = 100;
                i_div[c] = 100;
                d_div[c] = 100;
                held_level[c] = '0;
                held_code[c] = CODE_IDLE;
            end
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MAX_DRIVE:   max_drive   <= i_cfg_data[11:0];
                    REG_INT_LIMIT:   int_limit   <= i_cfg_data;
                    REG_GOAL_WINDOW: goal_window <= i_cfg_data[9:0];
                    REG_SPEED_SCALE: speed_scale <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                o_results <= o_results + 1;
                if (drive_q.size() == 0) begin
                    $display("%0t: unexpected result ch=%0d level=%0d code=%0d active=%0d",
                             $time, i_out_channel, i_drive_level, i_drive_code, i_active);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_d = drive_q.pop_front();
                    if (exp_d != {i_out_channel, i_drive_level, i_drive_code, i_active}) begin
                        $display("%0t: mismatch expected ch=%0d level=%0d code=%0d active=%0d, got ch=%0d level=%0d code=%0d active=%0d",
                                 $time, exp_d.chan, exp_d.level, exp_d.code, exp_d.active,
                                 i_out_channel, i_drive_level, i_drive_code, i_active);
                        o_errors <= o_errors + 1;
                    end
                    if (exp_d.code == CODE_BRAKE) o_brakes <= o_brakes + 1;
                    if (exp_d.active) o_regulating <= o_regulating + 1;
                end
            end
            if (i_valid && i_in_ready)
                drive_q.push_back(regulate_tick());
        end
    end

    initial begin
        o_errors = 0;
        o_results = 0;
        o_brakes = 0;
        o_regulating = 0;
    end

endmodule

### tb/sv/tb_multi_mode_motor_pid.sv
`timescale 1ns / 1ps

module tb_multi_mode_motor_pid;
    import mmpid_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_TICKS = 1630;

    typedef struct {
        logic [1:0]         chan;
        logic [1:0]         mode;
        logic signed [31:0] pos;
        logic signed [31:0] gpos;
        logic signed [31:0] gspd;
        logic signed [15:0] kpn, kpd, kin, kid, kdn, kdd;
    } tick_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [1:0] i_channel = '0;
    logic [1:0] i_mode = MODE_OFF;
    logic signed [31:0] i_position = '0, i_goal_position = '0, i_goal_speed = '0;
    logic signed [15:0] i_kp_num = '0, i_kp_den = '0, i_ki_num = '0;
    logic signed [15:0] i_ki_den = '0, i_kd_num = '0, i_kd_den = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [1:0] o_out_channel;
    logic [11:0] o_drive_level;
    logic [1:0] o_drive_code;
    logic o_active;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = REG_MAX_DRIVE;
    logic [15:0] i_cfg_data = '0;

    int errors, pending, results, brakes, regulating;
    int cycles = 0;
    int ticks_sent = 0;
    bit no_idle = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    multi_mode_motor_pid u_top (.*);

    mmpid_checker u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_in_ready(o_ready), .i_channel, .i_mode,
        .i_position, .i_goal_position, .i_goal_speed, .i_kp_num, .i_kp_den,
        .i_ki_num, .i_ki_den, .i_kd_num, .i_kd_den,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_out_channel(o_out_channel),
        .i_drive_level(o_drive_level), .i_drive_code(o_drive_code), .i_active(o_active),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_brakes(brakes), .o_regulating(regulating)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result receiver: a random stall before each item, plus one long hold-off.
    initial begin
        int wait_n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            wait_n = no_idle ? 0 : $urandom_range(0, 3);
            i_ready = 1'b0;
            repeat (wait_n) @(negedge i_clk);
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_tick(tick_t t);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_channel = t.chan;
        i_mode = t.mode;
        i_position = t.pos;
        i_goal_position = t.gpos;
        i_goal_speed = t.gspd;
        i_kp_num = t.kpn; i_kp_den = t.kpd;
        i_ki_num = t.kin; i_ki_den = t.kid;
        i_kd_num = t.kdn; i_kd_den = t.kdd;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic write_regs(logic [15:0] drive, logic [15:0] limit, logic [15:0] window,
                              logic [15:0] scale);
        logic [15:0] vals[4];
        vals = '{drive, limit, window, scale};
        // Every item yields a result, so an empty queue means an idle block.
        i_valid = 1'b0;
        wait (pending == 0);
        repeat (80) @(negedge i_clk);
        for (int r = 0; r < 4; r++) begin
            i_cfg_we = 1'b1;
            i_cfg_idx = r[1:0];
            i_cfg_data = vals[r];
            @(negedge i_clk);
        end
        i_cfg_we = 1'b0;
    endtask

    function automatic logic signed [15:0] rand_gain();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 16'sd0;
            default: return $signed(16'($urandom_range(0, 400))) - 16'sd200;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_den();
        case ($urandom_range(0, 4))
            0: return 16'sd0;
            1: return $urandom;
            default: return $signed(16'($urandom_range(1, 200))) * ($urandom_range(0, 1) ? 1 : -1);
        endcase
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        t.chan = $urandom_range(0, 3);
        t.mode = $urandom_range(0, 3);
        if ($urandom_range(0, 9) == 0) begin
            // Noise: raw values over the full field ranges.
            t.pos = $urandom;
            t.gpos = $urandom;
            t.gspd = $urandom;
        end else begin
            t.pos = $signed($urandom_range(0, 4000)) - 2000;
            t.gpos = t.pos + ($signed($urandom_range(0, 600)) - 300);
            if ($urandom_range(0, 3) == 0)
                t.gpos = t.pos + ($signed($urandom_range(0, 40)) - 20);
            t.gspd = $signed($urandom_range(0, 20000)) - 10000;
        end
        t.kpn = rand_gain(); t.kpd = rand_den();
        t.kin = rand_gain(); t.kid = rand_den();
        t.kdn = rand_gain(); t.kdd = rand_den();
        return t;
    endfunction

    function automatic tick_t mk(logic [1:0] ch, logic [1:0] md, int p, int gp, int gs,
                                 int kpn, int kpd, int kin, int kid, int kdn, int kdd);
        tick_t t;
        t.chan = ch; t.mode = md; t.pos = p; t.gpos = gp; t.gspd = gs;
        t.kpn = kpn; t.kpd = kpd; t.kin = kin; t.kid = kid; t.kdn = kdn; t.kdd = kdd;
        return t;
    endfunction

    initial begin
        tick_t d[$];
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        d.push_back(mk(0, MODE_OFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(mk(0, MODE_POS, 0, 1000, 0, 50, 0, 5, 0, 10, 0));
        d.push_back(mk(1, MODE_POS, 500, 500, 0, 50, 7, 5, 9, 10, 11));
        d.push_back(mk(1, MODE_POS, 500, 505, 0, 50, 0, 5, 0, 10, 0));
        d.push_back(mk(1, MODE_OFF, 0, 0, 0, 1, 0, 1, 0, 1, 0));
        d.push_back(mk(2, MODE_SPEED, 100, 0, 3000, 40, 0, 5, 0, 3, 0));
        d.push_back(mk(2, MODE_SPEED, 140, 0, -3000, -32768, -32768, 32767, 32767, -32768, 1));
        d.push_back(mk(3, MODE_POS_SPD, 0, 1000, -50, 20, 0, 2, 0, 1, 0));
        d.push_back(mk(3, MODE_POS_SPD, 1000, 0, 50, 20, 0, 2, 0, 1, 0));
        d.push_back(mk(3, MODE_POS_SPD, 0, 1000, 50, 20, 0, 2, 0, 1, 0));
        d.push_back(mk(0, MODE_POS, 7, 7, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(mk(0, MODE_SPEED, 0, 0, 0, 0, 1, 0, 1, 0, 1));
        d.push_back(mk(1, MODE_POS, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32767, 1, 32767, 1, 32767, 1));
        d.push_back(mk(1, MODE_POS, 32'h7FFF_FFFF, 32'h8000_0000, 0, -32768, 1, -32768, 1, -32768, 1));
        d.push_back(mk(2, MODE_SPEED, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32767, -1, 32767, -1, 32767, -1));
        d.push_back(mk(2, MODE_SPEED, 32'h7FFF_FFFF, 0, 32'h8000_0000, -32768, -1, 1, 3, -1, 3));
        d.push_back(mk(3, MODE_POS_SPD, -5000, 5000, 32'h7FFF_FFFF, 100, 0, 100, 0, 100, 0));
        d.push_back(mk(3, MODE_OFF, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        d.push_back(mk(0, MODE_POS, -100, -300, 0, -7, 3, 11, -4, 5, -6));
        d.push_back(mk(0, MODE_POS, -120, -300, 0, -7, 0, 11, 0, 5, 0));
        foreach (d[k]) send_tick(d[k]);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1: write_regs(16'd0, 16'd0, 16'd0, 16'd0);
                2: write_regs(16'd4095, 16'd65535, 16'd1023, 16'd255);
                3: write_regs($urandom_range(0, 4095), $urandom, $urandom_range(0, 1023),
                              $urandom_range(0, 255));
                default: ;
            endcase
            for (int n = 0; n < RANDOM_TICKS / 4; n++) begin
                if (phase == 1 && n == 20) hold_req = 1'b1;
                no_idle = (n % 100) >= 80;
                send_tick(rand_tick());
            end
            no_idle = 1'b0;
        end
        write_regs(MAX_DRIVE_RST, INT_LIMIT_RST, GOAL_WINDOW_RST, SPEED_SCALE_RST);
        for (int n = 0; n < 20; n++) send_tick(rand_tick());
        i_valid = 1'b0;

        wait (pending == 0);
        repeat (100) @(negedge i_clk);
        $display("Sent %0d control ticks over five register settings and got %0d results,",
                 ticks_sent, results);
        $display("%0d of them regulating and %0d braking at the goal.", regulating, brakes);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
